@@ rtl/hrhs_pkg.sv @@
// Shared types, byte codes and helpers for the HTTP request header scanner.
`timescale 1ns / 1ps

package hrhs_pkg;

    localparam int BYTE_W  = 8;
    localparam int STATE_W = 4;

    typedef enum logic [STATE_W-1:0] {
        ST_START   = 4'd0,
        ST_METHOD  = 4'd1,
        ST_SPACE1  = 4'd2,
        ST_URI     = 4'd3,
        ST_SPACE2  = 4'd4,
        ST_VERSION = 4'd5,
        ST_EOL     = 4'd6,
        ST_NAME    = 4'd7,
        ST_COLON   = 4'd8,
        ST_VALUE   = 4'd9,
        ST_END     = 4'd10
    } parse_state_t;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b == CH_SP) || (b == CH_CR) || (b == CH_LF) || (b == CH_TAB);
    endfunction

endpackage

@@ rtl/hrhs_byte_reg.sv @@
// Input register stage: holds one byte item until the parser takes it.
`timescale 1ns / 1ps

module hrhs_byte_reg
    import hrhs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              byte_valid,
    input  logic              byte_ready,
    output logic [BYTE_W-1:0] byte_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              take;

    // refill in the same cycle the held item drains
    assign take    = valid_reg && byte_ready;
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

@@ rtl/hrhs_fsm.sv @@
// Parse state machine with the result register.
`timescale 1ns / 1ps

module hrhs_fsm
    import hrhs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [BYTE_W-1:0]  byte_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STATE_W-1:0] m_parse_state
);

    parse_state_t       state_reg;
    parse_state_t       state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [STATE_W-1:0] out_state_reg;
    logic               accept;
    logic               lf;
    logic               ws;

    assign byte_ready = !out_valid_reg || m_ready;
    assign accept     = byte_valid && byte_ready;
    assign lf         = (byte_data == CH_LF);
    assign ws         = is_ws(byte_data);

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            unique case (state_reg)
                ST_START:   state_next = ws ? ST_START : ST_METHOD;
                ST_METHOD:  state_next = lf ? ST_EOL : (ws ? ST_SPACE1 : ST_METHOD);
                ST_SPACE1:  state_next = lf ? ST_EOL : (ws ? ST_SPACE1 : ST_URI);
                ST_URI:     state_next = lf ? ST_EOL : (ws ? ST_SPACE2 : ST_URI);
                ST_SPACE2:  state_next = lf ? ST_EOL : (ws ? ST_SPACE2 : ST_VERSION);
                ST_VERSION: state_next = lf ? ST_EOL : ST_VERSION;
                ST_EOL: begin
                    priority if (byte_data == CH_CR) begin
                        state_next = ST_EOL;
                    end else if (lf) begin
                        state_next = ST_END;
                    end else if (byte_data == CH_COLON) begin
                        state_next = ST_COLON;
                    end else begin
                        state_next = ST_NAME;
                    end
                end
                ST_NAME:    state_next = lf ? ST_EOL
                                       : ((byte_data == CH_COLON) ? ST_COLON : ST_NAME);
                ST_COLON:   state_next = lf ? ST_EOL : (ws ? ST_COLON : ST_VALUE);
                ST_VALUE:   state_next = lf ? ST_EOL : ST_VALUE;
                ST_END:     state_next = ST_END;
                // stray codes fall into the absorbing end state
                default:    state_next = ST_END;
            endcase
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_START;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_state_reg <= STATE_W'(state_next);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_parse_state = out_state_reg;

    a_reset_start: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == ST_START) && !out_valid_reg)
        else $error("state not cleared by reset");

    a_out_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (out_state_reg == STATE_W'(state_reg)) && out_valid_reg)
        else $error("result register does not match state");

    a_end_absorbs: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_END |=> state_reg == ST_END)
        else $error("left the end state");

    a_state_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("state moved without an item");

endmodule

@@ rtl/http_request_header_scanner.sv @@
// A byte accepted is held in the input register; its parse state is then registered in the
// result register, which holds it until m_ready takes it.
// Throughput: one byte per cycle while the output is not stalled; the state register
// feeds back through one next-state decode, so each accepted byte updates the state.
// Reset (aresetn low, synchronous) returns the parser to the start state
// and empties both the input register and the result register.
`timescale 1ns / 1ps

module http_request_header_scanner
    import hrhs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STATE_W-1:0] m_parse_state
);

    logic              byte_valid;
    logic              byte_ready;
    logic [BYTE_W-1:0] byte_data;

    hrhs_byte_reg u_byte_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data)
    );

    hrhs_fsm u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_data     (byte_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_parse_state (m_parse_state)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the HTTP request header scanner: byte stream in, parse state out.
`timescale 1ns / 1ps

module testbench;
    import hrhs_pkg::*;

    localparam int RANDOM_BYTES = 1700;
    localparam int END_BYTES    = 30;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              typed;
        parse_state_t      state;
    } scan_row_t;

    // Walk the request line once, then a few header lines; stop short of the end state,
    // which is absorbing and would hide everything after it.
    localparam int N_ROWS = 24;
    localparam scan_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{CH_SP,    1'b1, ST_START},   // leading whitespace
        '{CH_TAB,   1'b1, ST_START},
        '{CH_LF,    1'b1, ST_START},
        '{8'h00,    1'b1, ST_METHOD},  // NUL is not whitespace
        '{8'hFF,    1'b0, ST_START},
        '{CH_SP,    1'b0, ST_START},
        '{CH_CR,    1'b0, ST_START},
        '{8'h2F,    1'b0, ST_START},
        '{8'h80,    1'b0, ST_START},
        '{CH_TAB,   1'b0, ST_START},
        '{CH_SP,    1'b0, ST_START},   // whitespace after the URI
        '{8'h48,    1'b0, ST_START},
        '{CH_SP,    1'b0, ST_START},   // whitespace inside the version
        '{CH_CR,    1'b0, ST_START},
        '{CH_LF,    1'b1, ST_EOL},
        '{CH_CR,    1'b1, ST_EOL},
        '{8'h48,    1'b0, ST_START},
        '{CH_COLON, 1'b0, ST_START},
        '{CH_SP,    1'b0, ST_START},
        '{8'h7F,    1'b0, ST_START},
        '{CH_TAB,   1'b0, ST_START},
        '{CH_LF,    1'b1, ST_EOL},
        '{CH_COLON, 1'b0, ST_START},
        '{CH_LF,    1'b1, ST_EOL}
    };

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic [BYTE_W-1:0]  s_data_byte = '0;
    logic               m_ready     = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [STATE_W-1:0] m_parse_state;

    scan_row_t    byte_stream[$];
    parse_state_t expected_states[$];
    parse_state_t gen_state    = ST_START;
    parse_state_t scan_state   = ST_START;
    scan_row_t    in_flight    = '0;
    int           error_count  = 0;
    int           cycle_count  = 0;
    int           result_count = 0;
    int           random_pushed = 0;
    int           tx_gap       = 0;
    bit           tx_calm      = 1'b0;
    int           rx_stall     = 0;
    bit           rx_calm      = 1'b0;
    bit           stream_done  = 1'b0;

    http_request_header_scanner uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_parse_state (m_parse_state)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic parse_state_t scan_next_state(parse_state_t cur, logic [BYTE_W-1:0] b);
        logic blank;
        logic lf;
        blank = (b == CH_SP) || (b == CH_CR) || (b == CH_LF) || (b == CH_TAB);
        lf    = (b == CH_LF);
        case (cur)
            ST_START:   return blank ? ST_START : ST_METHOD;
            ST_METHOD:  return lf ? ST_EOL : (blank ? ST_SPACE1 : ST_METHOD);
            ST_SPACE1:  return lf ? ST_EOL : (blank ? ST_SPACE1 : ST_URI);
            ST_URI:     return lf ? ST_EOL : (blank ? ST_SPACE2 : ST_URI);
            ST_SPACE2:  return lf ? ST_EOL : (blank ? ST_SPACE2 : ST_VERSION);
            ST_VERSION: return lf ? ST_EOL : ST_VERSION;
            ST_EOL: begin
                if (b == CH_CR) return ST_EOL;
                if (lf) return ST_END;
                return (b == CH_COLON) ? ST_COLON : ST_NAME;
            end
            ST_NAME:    return lf ? ST_EOL : ((b == CH_COLON) ? ST_COLON : ST_NAME);
            ST_COLON:   return lf ? ST_EOL : (blank ? ST_COLON : ST_VALUE);
            ST_VALUE:   return lf ? ST_EOL : ST_VALUE;
            default:    return ST_END;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        case ($urandom_range(0, 9))
            8:       return BYTE_W'($urandom_range(8'h80, 8'hFF));
            9:       return BYTE_W'($urandom_range(8'h00, 8'h1F));
            default: return BYTE_W'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_LF;
            4:       return CH_COLON;
            5:       return 8'h00;
            6:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic push_item(logic [BYTE_W-1:0] b, logic typed, parse_state_t st);
        scan_row_t row;
        row.data  = b;
        row.typed = typed;
        row.state = st;
        gen_state = scan_next_state(gen_state, b);
        byte_stream.push_back(row);
    endtask

    task automatic push_text(logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = b;
        if ($urandom_range(0, 99) < 8) v = noise_byte();
        // keep out of the end state: no LF right after an end of line
        while (gen_state == ST_EOL && v == CH_LF)
            v = $urandom_range(0, 1) ? CH_CR : text_byte();
        random_pushed++;
        push_item(v, 1'b0, ST_START);
    endtask

    task automatic push_header_line();
        int n;
        if ($urandom_range(0, 7) == 0) push_text(CH_CR);
        n = $urandom_range(1, 12);
        repeat (n) push_text(text_byte());
        push_text(CH_COLON);
        n = $urandom_range(0, 3);
        repeat (n) push_text($urandom_range(0, 1) ? CH_SP : CH_TAB);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 20);
        repeat (n) push_text(($urandom_range(0, 5) == 0) ? CH_SP : text_byte());
        if ($urandom_range(0, 1)) push_text(CH_CR);
        push_text(CH_LF);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d result %0d: %s", cycle_count, result_count, what);
        error_count++;
    endtask

    initial begin
        for (int i = 0; i < N_ROWS; i++)
            push_item(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].state);
        while (random_pushed < RANDOM_BYTES)
            push_header_line();
        // close the head: one text byte, end of line, empty line, then bytes in the end state
        push_item(8'h78, 1'b0, ST_START);
        push_item(CH_LF, 1'b1, ST_EOL);
        push_item(CH_LF, 1'b1, ST_END);
        repeat (END_BYTES) push_item(noise_byte(), 1'b1, ST_END);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (!stream_done) begin
            @(posedge aclk);
            if (s_valid && !s_ready) continue;
            if (tx_gap > 0) begin
                s_valid <= 1'b0;
                tx_gap--;
            end else if (byte_stream.size() > 0) begin
                in_flight   <= byte_stream[0];
                s_data_byte <= byte_stream[0].data;
                s_valid     <= 1'b1;
                void'(byte_stream.pop_front());
                tx_gap = pick_gap(tx_calm);
                if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
            end else begin
                s_valid <= 1'b0;
                stream_done = 1'b1;
            end
        end

        // let the checker log the last accepted item before waiting on the queue
        @(posedge aclk);
        while (expected_states.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
            rx_stall = pick_gap(rx_calm);
        end
        if ($urandom_range(0, 127) == 0) rx_calm = !rx_calm;
    end

    always @(posedge aclk) begin
        parse_state_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                scan_state = scan_next_state(scan_state, s_data_byte);
                expected_states.push_back(in_flight.typed ? in_flight.state : scan_state);
            end
            if (m_valid && m_ready) begin
                if (expected_states.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, parse_state %0d",
                                              m_parse_state));
                end else begin
                    want = expected_states.pop_front();
                    if (m_parse_state !== want)
                        report_mismatch($sformatf("parse_state %0d, expected %0d",
                                                  m_parse_state, want));
                end
                result_count++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

endmodule
